FILE: src/b64lw_pkg.sv
// b64lw_pkg: beat types, group record and character constants for the
// Base64 line-wrap encoder. No dependencies.
`default_nettype none

package b64lw_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_end;
	} char_beat_t;

	// one encoded group: four symbols, plus an optional newline as fifth char
	typedef struct packed {
		logic [3:0][7:0] sym;
		logic            nl;
	} group_t;

	localparam logic [7:0] CHAR_PAD     = 8'h3D;
	localparam logic [7:0] CHAR_NL      = 8'h0A;
	localparam logic [7:0] LINE_LEN_RST = 8'd76;

	// standard alphabet: A-Z a-z 0-9 + /
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] r;
		r = 8'h2F;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + ({2'b00, v} - 8'd26);
		end else if (v < 6'd62) begin
			r = 8'h30 + ({2'b00, v} - 8'd52);
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/base64_line_wrap_encoder.sv
// base64_line_wrap_encoder: top level, input register and line length
// register. Depends on b64lw_pkg, b64lw_encode, b64lw_serializer.
//
// Usage:
//   byte channel: byte_valid / byte_stall / byte_data, one raw byte per beat,
//     final_byte set on the last byte of a stream.
//   char channel: char_valid / char_stall / char_data, one character per
//     beat; run_end marks the last character caused by one input byte.
//   cfg channel: cfg_valid / cfg_ready / cfg_data writes line_length
//     (reset 76); cfg_ready is always high. Write only while idle.
//   The byte that completes a group is held in the input register; the
//     group's first character then comes from the character register.
//   Throughput: bytes that only fill the group are taken without waiting;
//     a group leaves the character register as four characters, or five
//     with a newline, one character per cycle when the receiver does not
//     stall. This output register sets the throughput.
//   A stall on the char side holds the current character; the input register
//     keeps taking bytes until it holds one that completes a group.
//   Reset clears all pending bytes, the line count and both valid flags.
`default_nettype none

module base64_line_wrap_encoder import b64lw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic byte_valid,
	output logic      byte_stall,
	input  byte_beat_t byte_data,
	output logic      char_valid,
	input  wire logic char_stall,
	output char_beat_t char_data,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [7:0] cfg_data
);

	byte_beat_t item_s1;
	logic       valid_s1;
	logic [7:0] len_q;

	group_t     grp;
	logic       grp_valid;
	logic       free;
	logic       advance;
	logic       load;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!grp_valid || free);
	assign load       = grp_valid && free;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LINE_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	b64lw_encode u_encode (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_length (len_q),
		.item        (item_s1),
		.item_valid  (valid_s1),
		.take        (advance),
		.grp         (grp),
		.grp_valid   (grp_valid)
	);

	b64lw_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp        (grp),
		.load       (load),
		.free       (free),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

endmodule

`default_nettype wire

FILE: src/b64lw_encode.sv
// b64lw_encode: pending-byte and line-count state plus the combinational
// group encoder. Depends on b64lw_pkg.
`default_nettype none

module b64lw_encode import b64lw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] line_length,
	input  byte_beat_t      item,
	input  wire logic       item_valid,
	input  wire logic       take,
	output group_t          grp,
	output logic            grp_valid
);

	logic [7:0] pend1_q;
	logic [7:0] pend2_q;
	logic [1:0] pcnt_q;
	logic [7:0] fill_q;

	logic [1:0] held;
	logic       emits;
	logic [7:0] b1, b2, b3;
	logic [8:0] fill_sum;
	logic       wrap;
	logic [7:0] fill_new;
	logic       trail;

	always_comb begin
		held     = (pcnt_q == 2'd3) ? 2'd2 : pcnt_q;
		emits    = item.final_byte || (held == 2'd2);
		b1       = (held == 2'd0) ? item.in_byte : pend1_q;
		b2       = (held == 2'd0) ? 8'h00 : ((held == 2'd1) ? item.in_byte : pend2_q);
		b3       = (held == 2'd2) ? item.in_byte : 8'h00;
		fill_sum = {1'b0, fill_q} + 9'd4;
		wrap     = fill_sum >= {1'b0, line_length};
		fill_new = wrap ? 8'h00 : fill_sum[7:0];
		trail    = item.final_byte && (fill_new != 8'h00);

		grp.sym[0] = b64_sym(b1[7:2]);
		grp.sym[1] = b64_sym({b1[1:0], b2[7:4]});
		grp.sym[2] = (held != 2'd0) ? b64_sym({b2[3:0], b3[7:6]}) : CHAR_PAD;
		grp.sym[3] = (held == 2'd2) ? b64_sym(b3[5:0]) : CHAR_PAD;
		grp.nl     = wrap || trail;
		grp_valid  = item_valid && emits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend1_q <= 8'h00;
			pend2_q <= 8'h00;
			pcnt_q  <= 2'd0;
			fill_q  <= 8'h00;
		end else if (take) begin
			if (emits) begin
				pend1_q <= 8'h00;
				pend2_q <= 8'h00;
				pcnt_q  <= 2'd0;
				fill_q  <= item.final_byte ? 8'h00 : fill_new;
			end else if (held == 2'd0) begin
				pend1_q <= item.in_byte;
				pcnt_q  <= 2'd1;
			end else begin
				pend2_q <= item.in_byte;
				pcnt_q  <= 2'd2;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/b64lw_serializer.sv
// b64lw_serializer: holds one encoded group and sends it one character
// per beat on the output channel. Depends on b64lw_pkg.
`default_nettype none

module b64lw_serializer import b64lw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  group_t    grp,
	input  wire logic load,
	output logic      free,
	output logic      char_valid,
	input  wire logic char_stall,
	output char_beat_t char_data
);

	group_t     grp_s2;
	logic [2:0] idx_s2;
	logic       valid_s2;

	logic       last;
	logic       fire;

	always_comb begin
		last                = (idx_s2 == (grp_s2.nl ? 3'd4 : 3'd3));
		fire                = valid_s2 && !char_stall;
		free                = !valid_s2 || (fire && last);
		char_valid          = valid_s2;
		char_data.out_char  = (idx_s2 == 3'd4) ? CHAR_NL : grp_s2.sym[idx_s2[1:0]];
		char_data.run_end   = last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s2 <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 3'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 3'd0;
		end else if (fire) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/b64lw_checker.sv
// b64lw_checker: port-level assertions for the encoder top level, and the
// bind that attaches them. Depends on b64lw_pkg.
`default_nettype none

module b64lw_checker import b64lw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_valid,
	input wire logic byte_stall,
	input byte_beat_t byte_data,
	input wire logic char_valid,
	input wire logic char_stall,
	input char_beat_t char_data
);

	a_char_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_data))
		else $error("char beat changed while stalled");

	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (char_data.out_char == CHAR_NL) |-> char_data.run_end)
		else $error("newline not last char of its run");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!char_valid |-> !byte_stall)
		else $error("input stalled with output empty");

	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && byte_data.final_byte && !char_valid
		|-> ##2 char_valid)
		else $error("final byte produced no output");

endmodule

bind base64_line_wrap_encoder b64lw_checker u_chk (.*);

`default_nettype wire
